/* rtl/p16l2_pkg.sv */
// Shared types and constants for the posit16 log2 block.
package p16l2_pkg;

  localparam int unsigned PositW = 16;
  localparam logic [PositW-1:0] NarPattern = 16'h8000;

  // Polynomial coefficients of the fractional log approximation
  localparam logic [31:0] CoefA = 32'd1661;
  localparam logic [31:0] CoefB = 32'd13209;
  localparam logic [31:0] CoefC = 32'd75694;
  localparam logic [31:0] CoefD = 32'd2017019;
  localparam logic [31:0] CoefE = 32'd96817627;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_REG   = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_JOIN  = 9'b000010000,
    ST_NORM  = 9'b000100000,
    ST_ROUND = 9'b001000000,
    ST_SIGN  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // Operation issued to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

/* rtl/p16l2_stream_if.sv */
// Valid/ready stream interface carrying one 16-bit posit.
interface p16l2_stream_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/p16l2_mul.sv */
// Shared 32x32 multiplier with registered product.
module p16l2_mul (
  input  logic                clk,
  input  p16l2_pkg::mul_req_t req,
  output logic [63:0]         prod
);
  import p16l2_pkg::*;

  logic [63:0] prod_r;

  // Register product on each issue
  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= 64'(req.a) * 64'(req.b);
    end
  end

  assign prod = prod_r;
endmodule

/* rtl/posit16_log2.sv */
// Top level of the posit16 (es=1) base-2 logarithm unit.
// One transaction in, one out. The block takes one operand at a time and
// is busy until its result is taken. An operand passes from acceptance to a
// valid result through a regime scan, a restoring divide, six multiplies on
// one shared 32x32 multiplier, a join step, a normalization with separate
// paths for |log2| of one or more and below that, then rounding and sign
// restore. An operand with a zero fraction skips the divide and the
// multiplies. Zero, negative and NaR operands go from the regime step
// straight to the output with a NaR result.
module posit16_log2 (
  input  logic          clk,
  input  logic          rst_n,
  p16l2_stream_if.sink   in_ch,
  p16l2_stream_if.source out_ch
);
  import p16l2_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] x_r;
  logic [6:0]  k_r;
  logic        nar_r;
  logic [4:0]  cnt_r;
  logic [2:0]  mstep_r;
  logic        mwait_r;
  logic [13:0] rem_r;
  logic [13:0] den_r;
  logic [31:0] z_r;
  logic [31:0] z2_r;
  logic [31:0] acc_r;
  logic [34:0] v_r;
  logic [5:0]  sh_r;
  logic        neg_r;
  logic        small_r;
  logic [15:0] res_r;
  mul_req_t    mreq;
  logic [63:0] prod;

  p16l2_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = res_r;

  // Multiplier operand selection per polynomial step
  always_comb begin
    mreq.start = (state_r == ST_MUL) && !mwait_r;
    mreq.a = z2_r;
    mreq.b = acc_r;
    unique case (mstep_r)
      3'd0:    begin mreq.a = z_r;  mreq.b = z_r; end
      3'd1:    begin mreq.b = CoefA; end
      3'd2:    begin mreq.b = CoefB + acc_r; end
      3'd3:    begin mreq.b = CoefC + acc_r; end
      3'd4:    begin mreq.b = CoefD + acc_r; end
      default: begin mreq.a = z_r;  mreq.b = CoefE + acc_r; end
    endcase
  end

  // Rounding helper terms
  logic [35:0] rv;
  logic [35:0] half;
  logic [35:0] rsum;
  logic [5:0]  rsh;
  always_comb begin
    rv = {1'b0, v_r};
    if (small_r) begin
      rsh = sh_r;
    end else begin
      rsh = 6'(sh_r + 6'd16);
    end
    half = 36'd1 << (rsh - 6'd1);
    if (((rv & half) != 0) && (((rv & (half - 36'd1)) != 0) || ((rv & (half << 1)) != 0))) begin
      rsum = rv + half;
    end else begin
      rsum = rv;
    end
  end

  logic [34:0] jv;
  assign jv = v_r | {1'b0, k_r[5:0], 28'd0};

  // Trial remainder of the restoring divide
  logic [14:0] div_trial;
  assign div_trial = {rem_r, 1'b0};

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_REG;
      ST_REG: begin
        if (nar_r) begin
          state_nxt = ST_OUT;
        end else if ((x_r[14] && !x_r[13]) || (!x_r[14] && x_r[13])) begin
          state_nxt = (x_r[11:0] != 12'd0) ? ST_DIV : ST_JOIN;
        end
      end
      ST_DIV:   if (cnt_r == 5'd28) state_nxt = ST_MUL;
      ST_MUL:   if (mwait_r && mstep_r == 3'd5) state_nxt = ST_JOIN;
      ST_JOIN:  state_nxt = ST_NORM;
      ST_NORM: begin
        if (small_r) begin
          if (v_r == 35'd0 || v_r[27]) state_nxt = ST_ROUND;
        end else if (v_r <= 35'h1FFFFFFF) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_SIGN;
      ST_SIGN:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        x_r     <= in_ch.data;
        nar_r   <= (in_ch.data == 16'd0) || in_ch.data[15];
        k_r     <= in_ch.data[14] ? 7'd0 : 7'h7E;
        res_r   <= NarPattern;
        cnt_r   <= '0;
        mstep_r <= '0;
        mwait_r <= 1'b0;
        v_r     <= '0;
      end
      ST_REG: begin
        if (!nar_r) begin
          if ((x_r[14] && x_r[13]) || (!x_r[14] && !x_r[13])) begin
            x_r <= x_r << 1;
            k_r <= x_r[14] ? 7'(k_r + 7'd2) : 7'(k_r - 7'd2);
          end else begin
            if (x_r[12]) k_r <= 7'(k_r + 7'd1);
            rem_r <= {2'b00, x_r[11:0]};
            den_r <= {2'b10, x_r[11:0]};
            z_r   <= '0;
          end
        end
      end
      ST_DIV: begin
        // Shift one restoring quotient bit per cycle, 29 bits of m/(m+8192)
        if (div_trial >= {1'b0, den_r}) begin
          rem_r <= 14'(div_trial - {1'b0, den_r});
          z_r   <= {z_r[30:0], 1'b1};
        end else begin
          rem_r <= div_trial[13:0];
          z_r   <= {z_r[30:0], 1'b0};
        end
        cnt_r <= 5'(cnt_r + 5'd1);
      end
      ST_MUL: begin
        mwait_r <= !mwait_r;
        if (mwait_r) begin
          mstep_r <= 3'(mstep_r + 3'd1);
          unique case (mstep_r)
            3'd0:    z2_r  <= 32'(prod >> 30);
            3'd1:    acc_r <= 32'(prod >> 25);
            3'd2:    acc_r <= 32'(prod >> 26);
            3'd3:    acc_r <= 32'(prod >> 24);
            3'd4:    acc_r <= 32'(prod >> 24);
            default: v_r   <= 35'(prod >> 26);
          endcase
        end
      end
      ST_JOIN: begin
        neg_r <= jv[33];
        if (jv[33]) begin
          v_r     <= 35'(35'h400000000 - jv);
          small_r <= (35'(35'h400000000 - jv) < 35'h10000000);
        end else begin
          v_r     <= jv;
          small_r <= (jv < 35'h10000000);
        end
        sh_r <= (jv[33] ? (35'(35'h400000000 - jv) < 35'h10000000)
                        : (jv < 35'h10000000)) ? 6'd30 : 6'd0;
      end
      ST_NORM: begin
        if (small_r) begin
          if (v_r != 35'd0 && !v_r[27]) begin
            v_r  <= v_r << 1;
            sh_r <= 6'(sh_r + 6'd1);
          end else if (v_r != 35'd0) begin
            v_r  <= (v_r ^ 35'h18000000) | {7'd0, ~sh_r[0], 27'd0};
            sh_r <= sh_r >> 1;
          end
        end else if (v_r > 35'h1FFFFFFF) begin
          v_r  <= (v_r & 35'd1) | (v_r >> 1);
          sh_r <= 6'(sh_r + 6'd1);
        end else begin
          v_r  <= ({7'd0, v_r[27:0]} | {6'd0, sh_r[0], 28'd0})
                  | 35'((36'h80000000 << sh_r[5:1]) - 36'h40000000);
          sh_r <= sh_r >> 1;
        end
      end
      ST_ROUND: begin
        if (small_r && v_r == 35'd0) begin
          res_r <= 16'd0;
        end else begin
          res_r <= 16'(rsum >> rsh);
        end
      end
      ST_SIGN: if (neg_r) res_r <= 16'(17'h10000 - {1'b0, res_r});
      default: ;
    endcase
  end
endmodule

/* rtl/p16l2_checker.sv */
// Port-level checker for the posit16 log2 unit, bound to the top level.
module p16l2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_data
);
  import p16l2_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_nar: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data[15] |=> ##1 out_valid && out_data == NarPattern)
    else $error("negative operand did not give NaR");
endmodule

bind posit16_log2 p16l2_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
